// ----- rtl/owts_pkg.sv -----
// Shared constants, codes and a helper function for the one-wire temperature sensor sequencer.
`default_nettype none

package owts_pkg;

    localparam int SCRATCHPAD_BYTES = 9;
    localparam int SP_INDEX_W = $clog2(SCRATCHPAD_BYTES + 1);

    // Event codes from the bit engine.
    localparam logic [2:0] OP_START      = 3'd0;
    localparam logic [2:0] OP_RESET_DONE = 3'd1;
    localparam logic [2:0] OP_BYTE_WRITTEN = 3'd2;
    localparam logic [2:0] OP_BYTE_READ  = 3'd3;
    localparam logic [2:0] OP_WAIT_DONE  = 3'd4;

    // Requests to the bit engine.
    localparam logic [1:0] ACT_RESET = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_WAIT  = 2'd3;

    // Sequencer stages.
    localparam logic [1:0] ST_WRITE_CFG = 2'd0;
    localparam logic [1:0] ST_CONVERT   = 2'd1;
    localparam logic [1:0] ST_READ      = 2'd2;

    // Steps within a stage.
    localparam logic [1:0] STEP_IDLE    = 2'd0;
    localparam logic [1:0] STEP_ROM     = 2'd1;
    localparam logic [1:0] STEP_COMMAND = 2'd2;
    localparam logic [1:0] STEP_READING = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_PRESENCE = 2'd1;
    localparam logic [1:0] ERR_READ     = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_ALARM_HIGH   = 3'd0;
    localparam logic [2:0] REG_ALARM_LOW    = 3'd1;
    localparam logic [2:0] REG_RESOLUTION   = 3'd2;
    localparam logic [2:0] REG_MAX_ERRORS   = 3'd3;
    localparam logic [2:0] REG_CONVERT_WAIT = 3'd4;
    localparam logic [2:0] REG_NO_PRES_WAIT = 3'd5;
    localparam logic [2:0] REG_ERROR_WAIT   = 3'd6;
    localparam logic [2:0] REG_REPEAT_WAIT  = 3'd7;

    // One-wire commands and fixed scratchpad contents.
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_WRITE_SP = 8'h4E;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;
    localparam logic [7:0] FIXED_BYTE5  = 8'hFF;
    localparam logic [7:0] FIXED_BYTE7  = 8'h10;

    localparam logic [SP_INDEX_W-1:0] USER_FIRST = SP_INDEX_W'(2);
    localparam logic [SP_INDEX_W-1:0] USER_END   = SP_INDEX_W'(5);
    localparam logic [SP_INDEX_W-1:0] SP_LAST    = SP_INDEX_W'(SCRATCHPAD_BYTES - 1);
    localparam logic [SP_INDEX_W-1:0] SP_COUNT   = SP_INDEX_W'(SCRATCHPAD_BYTES);

    localparam logic [13:0] FRAC_STEP = 14'(10000 / 16);
    localparam logic [7:0]  CRC_POLY  = 8'h8C;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  action_byte;
        logic [15:0] wait_ticks;
        logic [1:0]  last_error;
        logic        temp_valid;
        logic        temp_sign;
        logic [11:0] temp_integer;
        logic [13:0] temp_fraction;
        logic        reading_done;
    } result_t;

    // Reflected Dallas CRC-8 over one byte, least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/onewire_temp_sensor_sequencer.sv -----
// Top level of the one-wire temperature sensor sequencer.
// Usage: the bit engine hands in one completion event per beat on the event
// channel (op, presence, read_data). For each event the block returns exactly
// one beat on the result channel: the next request for the bit engine
// (reset pulse, byte to write, byte read or wait) together with the held
// temperature and status. Configuration registers are written through the
// cfg_write/cfg_index/cfg_data port; the user must write them only while no
// event is in flight, as the block itself does not enforce this.
// The event is registered, then the sequencer, CRC and temperature logic
// compute the result in one pass into the result register.
// Throughput: one event per cycle while results are taken; the result
// register and the event register form a two-entry pipeline, so a new event
// is taken while a finished result still waits to be taken.
// When the receiver stalls, the result is held and the pipeline fills; the
// event channel stops accepting once both registers are occupied.
// Reset returns the sequencer to the configuration write stage with no valid
// temperature, clears the error count and loads the default register values.
// The scratchpad copy needs no clearing: every entry is written before it is read.
`default_nettype none

module onewire_temp_sensor_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        event_valid,
    output logic             event_ready,
    input  wire logic [2:0]  op,
    input  wire logic        presence,
    input  wire logic [7:0]  read_data,

    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       action,
    output logic [7:0]       action_byte,
    output logic [15:0]      wait_ticks,
    output logic [1:0]       last_error,
    output logic             temp_valid,
    output logic             temp_sign,
    output logic [11:0]      temp_integer,
    output logic [13:0]      temp_fraction,
    output logic             reading_done
);

    // Configuration registers.
    logic [7:0]  alarm_high_reg;
    logic [7:0]  alarm_low_reg;
    logic [7:0]  resolution_reg;
    logic [7:0]  max_errors_reg;
    logic [15:0] convert_wait_reg;
    logic [15:0] no_pres_wait_reg;
    logic [15:0] error_wait_reg;
    logic [15:0] repeat_wait_reg;

    // Event register.
    logic        ev_valid_reg;
    logic [2:0]  op_reg;
    logic        presence_reg;
    logic [7:0]  read_data_reg;

    // Result register.
    logic                res_valid_reg;
    owts_pkg::result_t   res_reg;
    owts_pkg::result_t   res_next;

    // Sequencer state.
    logic [1:0]  stage_reg, stage_next;
    logic [1:0]  step_reg, step_next;
    logic [owts_pkg::SP_INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  error_count_reg, error_count_next;
    logic        valid_flag_reg, valid_flag_next;
    logic [1:0]  error_code_reg, error_code_next;
    logic        held_sign_reg, held_sign_next;
    logic [11:0] held_integer_reg, held_integer_next;
    logic [13:0] held_fraction_reg, held_fraction_next;

    logic [7:0]  sp_reg [owts_pkg::SCRATCHPAD_BYTES];
    logic        load_user;
    logic        store_byte;

    logic        advance;

    // Combinational helpers.
    logic [7:0]  crc_new;
    logic        read_bad;
    logic [15:0] temp_word;
    logic [15:0] temp_mag;
    logic [15:0] repeat_wait;
    logic [7:0]  error_count_inc;
    logic [1:0]  act_c;
    logic [7:0]  abyte_c;
    logic [15:0] wt_c;
    logic        done_c;
    logic        unexpected;

    assign advance      = ev_valid_reg && (!res_valid_reg || result_ready);
    assign event_ready  = !ev_valid_reg || advance;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_high_reg   <= 8'd0;
            alarm_low_reg    <= 8'd0;
            resolution_reg   <= 8'd127;
            max_errors_reg   <= 8'd3;
            convert_wait_reg <= 16'd750;
            no_pres_wait_reg <= 16'd1000;
            error_wait_reg   <= 16'd1000;
            repeat_wait_reg  <= 16'd250;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                owts_pkg::REG_ALARM_HIGH:   alarm_high_reg   <= cfg_data[7:0];
                owts_pkg::REG_ALARM_LOW:    alarm_low_reg    <= cfg_data[7:0];
                owts_pkg::REG_RESOLUTION:   resolution_reg   <= cfg_data[7:0];
                owts_pkg::REG_MAX_ERRORS:   max_errors_reg   <= cfg_data[7:0];
                owts_pkg::REG_CONVERT_WAIT: convert_wait_reg <= cfg_data;
                owts_pkg::REG_NO_PRES_WAIT: no_pres_wait_reg <= cfg_data;
                owts_pkg::REG_ERROR_WAIT:   error_wait_reg   <= cfg_data;
                owts_pkg::REG_REPEAT_WAIT:  repeat_wait_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Event and result handshake control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (event_ready)
            begin
                ev_valid_reg <= event_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (event_valid && event_ready)
        begin
            op_reg        <= op;
            presence_reg  <= presence;
            read_data_reg <= read_data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // Local copy of the sensor scratchpad.
    always_ff @(posedge clk)
    begin
        if (advance && load_user)
        begin
            sp_reg[2] <= alarm_high_reg;
            sp_reg[3] <= alarm_low_reg;
            sp_reg[4] <= resolution_reg;
        end
        if (advance && store_byte)
        begin
            sp_reg[byte_index_reg] <= read_data_reg;
        end
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg         <= owts_pkg::ST_WRITE_CFG;
            step_reg          <= owts_pkg::STEP_IDLE;
            byte_index_reg    <= '0;
            crc_reg           <= 8'd0;
            error_count_reg   <= 8'd0;
            valid_flag_reg    <= 1'b0;
            error_code_reg    <= owts_pkg::ERR_NONE;
            held_sign_reg     <= 1'b0;
            held_integer_reg  <= 12'd0;
            held_fraction_reg <= 14'd0;
        end
        else if (advance)
        begin
            stage_reg         <= stage_next;
            step_reg          <= step_next;
            byte_index_reg    <= byte_index_next;
            crc_reg           <= crc_next;
            error_count_reg   <= error_count_next;
            valid_flag_reg    <= valid_flag_next;
            error_code_reg    <= error_code_next;
            held_sign_reg     <= held_sign_next;
            held_integer_reg  <= held_integer_next;
            held_fraction_reg <= held_fraction_next;
        end
    end

    // Read check and temperature conversion for the final scratchpad byte.
    assign crc_new   = owts_pkg::crc8_byte(crc_reg, read_data_reg);
    assign read_bad  = (crc_new != 8'd0) ||
                       (sp_reg[2] != alarm_high_reg) ||
                       (sp_reg[3] != alarm_low_reg) ||
                       (sp_reg[4] != resolution_reg) ||
                       (sp_reg[5] != owts_pkg::FIXED_BYTE5) ||
                       (sp_reg[7] != owts_pkg::FIXED_BYTE7);
    assign temp_word = {sp_reg[1], sp_reg[0]};
    assign temp_mag  = temp_word[15] ? (~temp_word + 16'd1) : temp_word;
    assign repeat_wait = (repeat_wait_reg > convert_wait_reg) ?
                         (repeat_wait_reg - convert_wait_reg) : 16'd0;
    assign error_count_inc = (error_count_reg != 8'hFF) ?
                             (error_count_reg + 8'd1) : error_count_reg;

    always_comb
    begin
        stage_next         = stage_reg;
        step_next          = step_reg;
        byte_index_next    = byte_index_reg;
        crc_next           = crc_reg;
        error_count_next   = error_count_reg;
        valid_flag_next    = valid_flag_reg;
        error_code_next    = error_code_reg;
        held_sign_next     = held_sign_reg;
        held_integer_next  = held_integer_reg;
        held_fraction_next = held_fraction_reg;
        load_user          = 1'b0;
        store_byte         = 1'b0;
        act_c              = owts_pkg::ACT_RESET;
        abyte_c            = 8'd0;
        wt_c               = 16'd0;
        done_c             = 1'b0;
        unexpected         = 1'b0;

        unique case (op_reg)
            owts_pkg::OP_START:
            begin
                stage_next = owts_pkg::ST_WRITE_CFG;
                step_next  = owts_pkg::STEP_IDLE;
            end
            owts_pkg::OP_RESET_DONE:
            begin
                if (!presence_reg)
                begin
                    error_code_next = owts_pkg::ERR_PRESENCE;
                    valid_flag_next = 1'b0;
                    stage_next      = owts_pkg::ST_WRITE_CFG;
                    step_next       = owts_pkg::STEP_IDLE;
                    act_c           = owts_pkg::ACT_WAIT;
                    wt_c            = no_pres_wait_reg;
                end
                else
                begin
                    error_code_next = owts_pkg::ERR_NONE;
                    step_next       = owts_pkg::STEP_ROM;
                    act_c           = owts_pkg::ACT_WRITE;
                    abyte_c         = owts_pkg::CMD_SKIP_ROM;
                end
            end
            owts_pkg::OP_BYTE_WRITTEN:
            begin
                if (step_reg == owts_pkg::STEP_ROM)
                begin
                    step_next = owts_pkg::STEP_COMMAND;
                    act_c     = owts_pkg::ACT_WRITE;
                    if (stage_reg == owts_pkg::ST_CONVERT)
                    begin
                        abyte_c = owts_pkg::CMD_CONVERT;
                    end
                    else if (stage_reg == owts_pkg::ST_READ)
                    begin
                        byte_index_next = '0;
                        crc_next        = 8'd0;
                        abyte_c         = owts_pkg::CMD_READ_SP;
                    end
                    else
                    begin
                        stage_next      = owts_pkg::ST_WRITE_CFG;
                        byte_index_next = owts_pkg::USER_FIRST;
                        load_user       = 1'b1;
                        abyte_c         = owts_pkg::CMD_WRITE_SP;
                    end
                end
                else if (step_reg == owts_pkg::STEP_COMMAND)
                begin
                    if (stage_reg == owts_pkg::ST_CONVERT)
                    begin
                        stage_next = owts_pkg::ST_READ;
                        step_next  = owts_pkg::STEP_IDLE;
                        act_c      = owts_pkg::ACT_WAIT;
                        wt_c       = convert_wait_reg;
                    end
                    else if (stage_reg == owts_pkg::ST_READ)
                    begin
                        step_next = owts_pkg::STEP_READING;
                        act_c     = owts_pkg::ACT_READ;
                    end
                    else if (byte_index_reg >= owts_pkg::USER_FIRST &&
                             byte_index_reg < owts_pkg::USER_END)
                    begin
                        // Send the user bytes 2 to 4 captured when the command went out.
                        act_c           = owts_pkg::ACT_WRITE;
                        abyte_c         = sp_reg[byte_index_reg];
                        byte_index_next = byte_index_reg + 1'b1;
                    end
                    else
                    begin
                        stage_next = owts_pkg::ST_CONVERT;
                        step_next  = owts_pkg::STEP_IDLE;
                    end
                end
                else
                begin
                    unexpected = 1'b1;
                end
            end
            owts_pkg::OP_BYTE_READ:
            begin
                if (step_reg == owts_pkg::STEP_READING &&
                    stage_reg == owts_pkg::ST_READ &&
                    byte_index_reg < owts_pkg::SP_COUNT)
                begin
                    store_byte      = 1'b1;
                    crc_next        = crc_new;
                    byte_index_next = byte_index_reg + 1'b1;
                    if (byte_index_reg == owts_pkg::SP_LAST)
                    begin
                        step_next = owts_pkg::STEP_IDLE;
                        act_c     = owts_pkg::ACT_WAIT;
                        if (read_bad)
                        begin
                            error_code_next  = owts_pkg::ERR_READ;
                            error_count_next = error_count_inc;
                            if (error_count_inc > max_errors_reg)
                            begin
                                valid_flag_next = 1'b0;
                            end
                            stage_next = owts_pkg::ST_WRITE_CFG;
                            wt_c       = error_wait_reg;
                        end
                        else
                        begin
                            held_sign_next     = temp_word[15];
                            held_integer_next  = temp_mag[15:4];
                            held_fraction_next = 14'(temp_mag[3:0]) * owts_pkg::FRAC_STEP;
                            error_code_next    = owts_pkg::ERR_NONE;
                            error_count_next   = 8'd0;
                            valid_flag_next    = 1'b1;
                            stage_next         = owts_pkg::ST_CONVERT;
                            wt_c               = repeat_wait;
                            done_c             = 1'b1;
                        end
                    end
                    else
                    begin
                        act_c = owts_pkg::ACT_READ;
                    end
                end
                else
                begin
                    unexpected = 1'b1;
                end
            end
            owts_pkg::OP_WAIT_DONE:
            begin
                step_next = owts_pkg::STEP_IDLE;
            end
            default:
            begin
                unexpected = 1'b1;
            end
        endcase

        // A beat that does not fit the pending request restarts with a reset pulse.
        if (unexpected)
        begin
            step_next = owts_pkg::STEP_IDLE;
            act_c     = owts_pkg::ACT_RESET;
        end

        res_next.action        = act_c;
        res_next.action_byte   = abyte_c;
        res_next.wait_ticks    = wt_c;
        res_next.last_error    = error_code_next;
        res_next.temp_valid    = valid_flag_next;
        res_next.temp_sign     = held_sign_next;
        res_next.temp_integer  = held_integer_next;
        res_next.temp_fraction = held_fraction_next;
        res_next.reading_done  = done_c;
    end

    assign result_valid  = res_valid_reg;
    assign action        = res_reg.action;
    assign action_byte   = res_reg.action_byte;
    assign wait_ticks    = res_reg.wait_ticks;
    assign last_error    = res_reg.last_error;
    assign temp_valid    = res_reg.temp_valid;
    assign temp_sign     = res_reg.temp_sign;
    assign temp_integer  = res_reg.temp_integer;
    assign temp_fraction = res_reg.temp_fraction;
    assign reading_done  = res_reg.reading_done;

    // A good reading always requests the repeat wait with a valid, error-free temperature.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && reading_done |->
            temp_valid && action == owts_pkg::ACT_WAIT && last_error == owts_pkg::ERR_NONE)
        else $error("good reading without valid temperature or wait request");

    // Byte and wait fields are zero unless the request uses them.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (action == owts_pkg::ACT_WRITE || action_byte == 8'd0) &&
            (action == owts_pkg::ACT_WAIT || wait_ticks == 16'd0))
        else $error("unused request field not zero");

    // The scratchpad index never runs past the number of bytes read.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= owts_pkg::SP_COUNT)
        else $error("scratchpad index out of range");

    // An event waiting behind a stalled result is neither lost nor consumed.
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg && !advance |=> ev_valid_reg && $stable(op_reg))
        else $error("pending event lost while result stalled");

endmodule

`default_nettype wire
